[design/irm_pkg.sv]
// Package for the I2C register master: phase constants, sample codes and
// the item and line-drive types. No dependencies.

package irm_pkg;

	localparam int PHASE_W = 7;

	localparam logic [PHASE_W-1:0] WRITE_LAST_PHASE = 7'd59;
	localparam logic [PHASE_W-1:0] READ_LAST_PHASE  = 7'd80;

	localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'd104;

	typedef enum logic [1:0] {
		SMP_NONE,
		SMP_ACK,
		SMP_DATA
	} smp_t;

	typedef struct packed {
		logic       scl;
		logic       sda;
		smp_t       smp;
	} line_drive_t;

	typedef struct packed {
		logic       kind;
		logic       is_read;
		logic [7:0] register_address;
		logic [7:0] write_data;
		logic       sda_in;
	} in_item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       ack_missing;
	} out_item_t;

endpackage

[design/irm_in_if.sv]
// Input channel of the I2C register master: valid/ready plus one tick or
// request item. No dependencies.

interface irm_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic       is_read;
	logic [7:0] register_address;
	logic [7:0] write_data;
	logic       sda_in;

	modport source (output valid, kind, is_read, register_address, write_data, sda_in,
		input ready);
	modport sink (input valid, kind, is_read, register_address, write_data, sda_in,
		output ready);
endinterface

[design/irm_out_if.sv]
// Result channel of the I2C register master: valid/ready plus bus levels
// and status. No dependencies.

interface irm_out_if;
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_level;
	logic       busy_res;
	logic       done_res;
	logic [7:0] read_data;
	logic       ack_missing;

	modport source (output valid, scl_level, sda_level, busy_res, done_res, read_data,
		ack_missing, input ready);
	modport sink (input valid, scl_level, sda_level, busy_res, done_res, read_data,
		ack_missing, output ready);
endinterface

[design/irm_cfg_if.sv]
// Configuration write channel of the I2C register master: valid/ready and
// the seven-bit device address. No dependencies.

interface irm_cfg_if;
	logic       valid;
	logic       ready;
	logic [6:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

[design/irm_phase_decode.sv]
// Phase decoder: maps a phase number to the SCL/SDA levels and the sample
// code of that phase. Depends on irm_pkg.

module irm_phase_decode (
	input  logic [irm_pkg::PHASE_W-1:0] phase,
	input  logic                        read_pending,
	input  logic [6:0]                  device_address,
	input  logic [7:0]                  register_address,
	input  logic [7:0]                  write_byte,
	output irm_pkg::line_drive_t        drive
);

	logic [7:0]                  wbyte;
	logic [irm_pkg::PHASE_W-1:0] off;

	// One byte slot: eight bits of low/high halves, then the acknowledge pair.
	function automatic irm_pkg::line_drive_t byte_phase(input logic [7:0] value,
		input logic [4:0] o);
		irm_pkg::line_drive_t d;
		d.scl = o[0];
		d.smp = irm_pkg::SMP_NONE;
		if (o < 5'd16) begin
			d.sda = value[3'd7 - o[3:1]];
		end else begin
			d.sda = 1'b1;
			if (o == 5'd17) begin
				d.smp = irm_pkg::SMP_ACK;
			end
		end
		return d;
	endfunction

	assign wbyte = {device_address, 1'b0};

	always_comb begin
		drive.scl = 1'b1;
		drive.sda = 1'b1;
		drive.smp = irm_pkg::SMP_NONE;
		off = '0;
		priority if (phase == '0) begin
			drive.scl = 1'b1;
		end else if (phase <= 7'd2) begin
			drive.sda = (phase == 7'd1);
		end else if (phase <= 7'd20) begin
			off = phase - 7'd3;
			drive = byte_phase(wbyte, off[4:0]);
		end else if (phase <= 7'd38) begin
			off = phase - 7'd21;
			drive = byte_phase(register_address, off[4:0]);
		end else if (!read_pending) begin
			priority if (phase <= 7'd56) begin
				off = phase - 7'd39;
				drive = byte_phase(write_byte, off[4:0]);
			end else if (phase <= irm_pkg::WRITE_LAST_PHASE) begin
				drive.scl = (phase != 7'd57);
				drive.sda = (phase == 7'd59);
			end else begin
				drive.scl = 1'b1;
			end
		end else begin
			// Read: repeated start, address with read bit, receive, NAK, stop.
			priority if (phase <= 7'd41) begin
				drive.scl = (phase != 7'd39);
				drive.sda = (phase != 7'd41);
			end else if (phase <= 7'd59) begin
				off = phase - 7'd42;
				drive = byte_phase(wbyte | 8'd1, off[4:0]);
			end else if (phase <= 7'd75) begin
				drive.scl = phase[0];
				if (phase[0]) begin
					drive.smp = irm_pkg::SMP_DATA;
				end
			end else if (phase <= 7'd77) begin
				drive.scl = (phase != 7'd76);
			end else if (phase <= irm_pkg::READ_LAST_PHASE) begin
				drive.scl = (phase != 7'd78);
				drive.sda = (phase == 7'd80);
			end else begin
				drive.scl = 1'b1;
			end
		end
	end

endmodule

[design/i2c_register_master.sv]
// Top level of the I2C register master: input register, phase sequencer and
// result register. Depends on irm_pkg, the irm_*_if interfaces and irm_phase_decode.
//
//   channel  | dir | carries
//   ---------+-----+---------------------------------------------------
//   items    | in  | tick or request: kind, is_read, register, data, sda_in
//   results  | out | scl/sda levels, busy, done, read byte, ack_missing
//   cfg      | in  | seven-bit device address
//
// Each item is registered, then, once the result register can take it, steps the
// phase counter and loads the result register; one item per cycle is sustained
// while results are taken. The result register stalls the input register while
// it is full and not taken; the input side stays open whenever the input register
// can drain in the same cycle. Reset puts the bus lines high and the master idle.

module i2c_register_master (
	input  logic       clk,
	input  logic       arst_n,
	irm_in_if.sink     items,
	irm_out_if.source  results,
	irm_cfg_if.sink    cfg
);

	logic                        valid_s1;
	irm_pkg::in_item_t           item_s1;
	logic                        out_valid_q;
	irm_pkg::out_item_t          out_q;

	logic [6:0]                  device_address_q;
	logic [irm_pkg::PHASE_W-1:0] phase_q;
	logic                        read_pending_q;
	logic [7:0]                  latched_register_q;
	logic [7:0]                  latched_write_byte_q;
	logic [7:0]                  receive_shift_q;
	logic                        ack_fault_q;

	logic [irm_pkg::PHASE_W-1:0] phase_d;
	logic [irm_pkg::PHASE_W-1:0] phase_inc;
	logic                        read_pending_d;
	logic [7:0]                  latched_register_d;
	logic [7:0]                  latched_write_byte_d;
	logic [7:0]                  receive_shift_d;
	logic                        ack_fault_d;
	logic [1:0]                  lines_d;
	logic                        done_d;
	logic [irm_pkg::PHASE_W-1:0] last_phase;

	irm_pkg::line_drive_t        cur_drive;
	irm_pkg::line_drive_t        nxt_drive;
	logic                        advance;

	assign advance = valid_s1 && (!out_valid_q || results.ready);
	assign items.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	assign phase_inc = phase_q + 7'd1;
	assign last_phase = read_pending_q ? irm_pkg::READ_LAST_PHASE : irm_pkg::WRITE_LAST_PHASE;

	irm_phase_decode u_cur_decode (
		.phase            (phase_q),
		.read_pending     (read_pending_q),
		.device_address   (device_address_q),
		.register_address (latched_register_q),
		.write_byte       (latched_write_byte_q),
		.drive            (cur_drive)
	);

	irm_phase_decode u_nxt_decode (
		.phase            (phase_inc),
		.read_pending     (read_pending_q),
		.device_address   (device_address_q),
		.register_address (latched_register_q),
		.write_byte       (latched_write_byte_q),
		.drive            (nxt_drive)
	);

	always_comb begin
		phase_d              = phase_q;
		read_pending_d       = read_pending_q;
		latched_register_d   = latched_register_q;
		latched_write_byte_d = latched_write_byte_q;
		receive_shift_d      = receive_shift_q;
		ack_fault_d          = ack_fault_q;
		lines_d              = {out_q.scl_level, out_q.sda_level};
		done_d               = 1'b0;
		if (item_s1.kind) begin
			// A request is taken only while idle; phase 1 keeps both lines high.
			if (phase_q == '0) begin
				read_pending_d       = item_s1.is_read;
				latched_register_d   = item_s1.register_address;
				latched_write_byte_d = item_s1.write_data;
				ack_fault_d          = 1'b0;
				phase_d              = 7'd1;
				lines_d              = 2'b11;
			end
		end else if (phase_q != '0) begin
			if (cur_drive.smp == irm_pkg::SMP_ACK && item_s1.sda_in) begin
				ack_fault_d = 1'b1;
			end else if (cur_drive.smp == irm_pkg::SMP_DATA) begin
				receive_shift_d = {receive_shift_q[6:0], item_s1.sda_in};
			end
			if (phase_q >= last_phase) begin
				phase_d = '0;
				lines_d = 2'b11;
				done_d  = 1'b1;
			end else begin
				phase_d = phase_inc;
				lines_d = {nxt_drive.scl, nxt_drive.sda};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.ready && items.valid) begin
			item_s1.kind             <= items.kind;
			item_s1.is_read          <= items.is_read;
			item_s1.register_address <= items.register_address;
			item_s1.write_data       <= items.write_data;
			item_s1.sda_in           <= items.sda_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q <= irm_pkg::DEVICE_ADDRESS_RESET;
		end else if (cfg.valid) begin
			device_address_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q              <= '0;
			read_pending_q       <= 1'b0;
			latched_register_q   <= '0;
			latched_write_byte_q <= '0;
			receive_shift_q      <= '0;
			ack_fault_q          <= 1'b0;
			out_valid_q          <= 1'b0;
			out_q                <= '{scl_level: 1'b1, sda_level: 1'b1, busy_res: 1'b0,
				done_res: 1'b0, read_data: 8'd0, ack_missing: 1'b0};
		end else begin
			if (advance) begin
				phase_q              <= phase_d;
				read_pending_q       <= read_pending_d;
				latched_register_q   <= latched_register_d;
				latched_write_byte_q <= latched_write_byte_d;
				receive_shift_q      <= receive_shift_d;
				ack_fault_q          <= ack_fault_d;
				out_q.scl_level      <= lines_d[1];
				out_q.sda_level      <= lines_d[0];
				out_q.busy_res       <= (phase_d != '0);
				out_q.done_res       <= done_d;
				out_q.read_data      <= receive_shift_d;
				out_q.ack_missing    <= ack_fault_d;
				out_valid_q          <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign results.valid       = out_valid_q;
	assign results.scl_level   = out_q.scl_level;
	assign results.sda_level   = out_q.sda_level;
	assign results.busy_res    = out_q.busy_res;
	assign results.done_res    = out_q.done_res;
	assign results.read_data   = out_q.read_data;
	assign results.ack_missing = out_q.ack_missing;

endmodule
